[rtl/core/range_coder_bypass_bits_defines.svh]
// Assertion macros used by the range coder top module.
`ifndef RANGE_CODER_BYPASS_BITS_DEFINES_SVH
`define RANGE_CODER_BYPASS_BITS_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define RCBB_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define RCBB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/rcbb_pkg.sv]
// Shared types and constants of the bypass-bit range coder.
package rcbb_pkg;

    localparam int unsigned C_VALUE_W      = 32;
    localparam int unsigned C_COUNT_W      = 6;
    localparam int unsigned C_BYTE_W       = 8;
    localparam int unsigned C_REP_W        = 32;
    localparam int unsigned C_LOW_W        = 33;
    localparam int unsigned C_RANGE_W      = 32;
    localparam int unsigned C_TOP_BITS     = 24;
    localparam int unsigned C_PEND_BITS    = 32;
    localparam int unsigned C_FLUSH_SHIFTS = 5;
    localparam int unsigned C_SHIFT_CNT_W  = $clog2(C_FLUSH_SHIFTS + 1);
    localparam int unsigned C_BUF_DEPTH    = 2 * C_FLUSH_SHIFTS;
    localparam int unsigned C_BUF_IDX_W    = $clog2(C_BUF_DEPTH);
    localparam int unsigned C_BUF_CNT_W    = $clog2(C_BUF_DEPTH + 1);

    typedef enum logic {
        OP_BITS  = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef struct packed {
        logic                 operation;
        logic [C_VALUE_W-1:0] value;
        logic [C_COUNT_W-1:0] bit_count;
    } t_req;

    typedef struct packed {
        logic [C_BYTE_W-1:0] byte_value;
        logic [C_REP_W-1:0]  repeat_res;
        logic                last;
    } t_res;

    typedef struct packed {
        logic [C_BYTE_W-1:0] byte_value;
        logic [C_REP_W-1:0]  repeat_res;
    } t_run;

    typedef struct packed {
        logic load;
        logic advance;
    } t_ser_ctl;

    typedef struct packed {
        logic bit_now;
        logic last;
        logic empty;
    } t_ser_stat;

    typedef struct packed {
        logic clear;
        logic push;
    } t_buf_ctl;

endpackage

[rtl/core/rcbb_bit_ser.sv]
// Bit serializer: presents the used bits of a request one per cycle while advanced, MSB first.
module rcbb_bit_ser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rcbb_pkg::t_ser_ctl               i_ctl,
    input  logic [rcbb_pkg::C_VALUE_W-1:0]   i_value,
    input  logic [rcbb_pkg::C_COUNT_W-1:0]   i_count,
    output rcbb_pkg::t_ser_stat              o_stat
);
    import rcbb_pkg::*;

    localparam int unsigned SH_W = $clog2(C_VALUE_W);

    logic [C_VALUE_W-1:0] r_shift, n_shift;
    logic [C_COUNT_W-1:0] r_left, n_left;
    logic [C_COUNT_W-1:0] count_sat;
    logic [C_COUNT_W-1:0] sh_amt;

    // Clamp the count and left-align the used bits
    always_comb begin
        count_sat = (i_count > C_COUNT_W'(C_VALUE_W)) ? C_COUNT_W'(C_VALUE_W) : i_count;
        sh_amt    = C_COUNT_W'(C_VALUE_W) - count_sat;
        n_shift   = r_shift;
        n_left    = r_left;
        if (i_ctl.load) begin
            n_shift = i_value << sh_amt[SH_W-1:0];
            n_left  = count_sat;
        end else if (i_ctl.advance) begin
            n_shift = r_shift << 1;
            n_left  = r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

    assign o_stat.bit_now = r_shift[C_VALUE_W-1];
    assign o_stat.last    = (r_left == C_COUNT_W'(1));
    assign o_stat.empty   = (r_left == '0);

endmodule

[rtl/core/rcbb_run_buf.sv]
// Run buffer: collects flush results and tracks the last nonzero byte run.
module rcbb_run_buf (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rcbb_pkg::t_buf_ctl                 i_ctl,
    input  rcbb_pkg::t_run                     i_wr,
    input  logic [rcbb_pkg::C_BUF_IDX_W-1:0]   i_rd_idx,
    output rcbb_pkg::t_run                     o_rd,
    output logic [rcbb_pkg::C_BUF_CNT_W-1:0]   o_keep
);
    import rcbb_pkg::*;

    t_run                   r_mem [C_BUF_DEPTH];
    t_run                   r_rd_data;
    logic [C_BUF_CNT_W-1:0] r_wr;
    logic [C_BUF_CNT_W-1:0] r_keep;
    logic                   wr_en;

    assign wr_en = i_ctl.push && (r_wr < C_BUF_CNT_W'(C_BUF_DEPTH));

    // Advance the fill count; remember the end of the last nonzero run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_keep <= '0;
        end else if (i_ctl.clear) begin
            r_wr   <= '0;
            r_keep <= '0;
        end else if (wr_en) begin
            r_wr <= r_wr + 1'b1;
            if (i_wr.byte_value != '0) begin
                r_keep <= r_wr + 1'b1;
            end
        end
    end

    // Store the run
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr[C_BUF_IDX_W-1:0]] <= i_wr;
        end
    end

    // Read the requested run; pass a run written this cycle straight through
    always_ff @(posedge i_clk) begin
        if (wr_en && (r_wr[C_BUF_IDX_W-1:0] == i_rd_idx)) begin
            r_rd_data <= i_wr;
        end else begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    assign o_rd   = r_rd_data;
    assign o_keep = r_keep;

endmodule

[rtl/core/rcbb_out_stage.sv]
// Output register: holds one result until the receiver takes it.
module rcbb_out_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  rcbb_pkg::t_res i_data,
    input  logic           i_ready,
    output logic           o_valid,
    output rcbb_pkg::t_res o_data,
    output logic           o_free
);
    import rcbb_pkg::*;

    logic r_valid;
    t_res r_data;

    assign o_free = !r_valid || i_ready;

    // Load a new result or drop the one taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[rtl/core/range_coder_bypass_bits.sv]
// Bypass-bit range encoder with carry propagation and end-of-stream flush.
//
// Requests arrive on i_req (valid/ready). A bits request codes bit_count low
// bits of value, one bit per cycle while in S_BIT, MSB first; a flush request ends the stream.
// Results leave on o_res (valid/ready) as byte runs: byte_value repeated
// repeat_res times; last marks the final run of a flush.
// Sequence: a bits request is accepted in S_IDLE, then codes its bits in S_BIT (count 0
// yields nothing), with S_SHIFT shifting a byte out of the low register and S_EMIT_C
// and S_EMIT_P releasing runs. A flush is accepted, rounded in S_ROUND, shifts its
// bytes out through S_SHIFT into the run buffer, then delivers its runs in S_DRAIN.
// The single bit-coding step per cycle (one 33-bit add and the range halving)
// sets the rate outside byte shifts and run releases; a new request is taken once
// the previous one has finished, while its last result may still sit in the output register.
// Reset (synchronous, active low) clears the coder to its start state and
// drops any held result; no clearing pass is needed.
// When the receiver stalls, the coder holds at the next run to deliver and
// resumes once the output register frees up.
`include "range_coder_bypass_bits_defines.svh"

module range_coder_bypass_bits #(
    parameter int unsigned PENDING_COUNT_BITS = rcbb_pkg::C_PEND_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  rcbb_pkg::t_req i_req,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output rcbb_pkg::t_res o_res
);
    import rcbb_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_BIT    = 7'b0000010,
        S_SHIFT  = 7'b0000100,
        S_EMIT_C = 7'b0001000,
        S_EMIT_P = 7'b0010000,
        S_ROUND  = 7'b0100000,
        S_DRAIN  = 7'b1000000
    } t_state;

    t_state                      r_state, n_state;
    logic [C_LOW_W-1:0]          r_low, n_low;
    logic [C_RANGE_W-1:0]        r_range, n_range;
    logic [C_BYTE_W-1:0]         r_cache, n_cache;
    logic [PENDING_COUNT_BITS-1:0] r_pend, n_pend;
    logic                        r_flush, n_flush;
    logic [C_SHIFT_CNT_W-1:0]    r_nshift, n_nshift;
    logic [C_BUF_IDX_W-1:0]      r_rd, n_rd;
    logic                        r_carry, n_carry;
    logic [C_BYTE_W-1:0]         r_rel_cache, n_rel_cache;
    logic [PENDING_COUNT_BITS-1:0] r_rel_pend, n_rel_pend;

    logic                        req_acc;
    t_ser_ctl                    ser_ctl;
    t_ser_stat                   ser_stat;
    t_buf_ctl                    buf_ctl;
    t_run                        emit_run;
    t_run                        buf_rd;
    logic [C_BUF_CNT_W-1:0]      buf_keep;
    logic                        out_load;
    logic                        out_free;
    t_res                        out_data;

    logic [C_RANGE_W-1:0]        bound;
    logic [C_RANGE_W-1:0]        range_c;
    logic                        need_shift;
    logic                        release_run;
    logic [C_SHIFT_CNT_W-1:0]    shifts_done;
    t_state                      cont_state;
    logic                        emit_go;
    logic                        drain_last;
    logic                        drain_fin;
    logic [2:0]                  msb_pos;
    logic [4:0]                  round_sh;
    logic [C_LOW_W-1:0]          round_unit;
    logic [C_LOW_W-1:0]          round_mask;

    assign o_req_ready = (r_state == S_IDLE);
    assign req_acc     = i_req_valid && o_req_ready;

    rcbb_bit_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ser_ctl),
        .i_value (i_req.value),
        .i_count (i_req.bit_count),
        .o_stat  (ser_stat)
    );

    // Fetch the run for the next drain cycle
    rcbb_run_buf u_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (buf_ctl),
        .i_wr     (emit_run),
        .i_rd_idx (n_rd),
        .o_rd     (buf_rd),
        .o_keep   (buf_keep)
    );

    rcbb_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_data  (out_data),
        .i_ready (i_res_ready),
        .o_valid (o_res_valid),
        .o_data  (o_res),
        .o_free  (out_free)
    );

    // Halve the range for the current bit
    always_comb begin
        bound   = r_range >> 1;
        range_c = ser_stat.bit_now ? (r_range - bound) : bound;
        need_shift = (range_c[C_RANGE_W-1:C_TOP_BITS] == '0);
    end

    // Decide whether a byte shift releases the cache byte and pending run
    assign release_run = r_low[C_LOW_W-1] ||
                         (r_low[C_RANGE_W-1 -: C_BYTE_W] != '1);

    // Find the rounding step from the top byte of the range
    always_comb begin
        msb_pos = '0;
        for (int i = 0; i < C_RANGE_W - C_TOP_BITS; i++) begin
            if (r_range[C_TOP_BITS + i]) begin
                msb_pos = 3'(i);
            end
        end
        round_sh   = 5'(C_TOP_BITS) + {2'b00, msb_pos};
        round_unit = C_LOW_W'(1) << round_sh;
        round_mask = round_unit - 1'b1;
    end

    // Pick the state that follows a shift or a released run
    always_comb begin
        shifts_done = (r_state == S_SHIFT) ? (r_nshift + 1'b1) : r_nshift;
        if (r_flush) begin
            cont_state = (shifts_done == C_SHIFT_CNT_W'(C_FLUSH_SHIFTS)) ? S_DRAIN : S_SHIFT;
        end else begin
            cont_state = ser_stat.empty ? S_IDLE : S_BIT;
        end
    end

    // Form the run being released
    always_comb begin
        if (r_state == S_EMIT_P) begin
            emit_run.byte_value = 8'hff + C_BYTE_W'(r_carry);
            emit_run.repeat_res = C_REP_W'(r_rel_pend - PENDING_COUNT_BITS'(1));
        end else begin
            emit_run.byte_value = r_rel_cache + C_BYTE_W'(r_carry);
            emit_run.repeat_res = C_REP_W'(1);
        end
    end

    assign emit_go    = r_flush || out_free;
    assign drain_last = (buf_keep == '0) ||
                        (r_rd == C_BUF_IDX_W'(buf_keep - 1'b1));
    assign drain_fin  = (r_state == S_DRAIN) && out_free && drain_last;

    // Route a run to the output register or to the run buffer
    always_comb begin
        buf_ctl.clear = req_acc && (i_req.operation == OP_FLUSH);
        buf_ctl.push  = r_flush && ((r_state == S_EMIT_C) || (r_state == S_EMIT_P));
        if (r_state == S_DRAIN) begin
            out_load = out_free;
            if (buf_keep == '0) begin
                out_data.byte_value = '0;
                out_data.repeat_res = '0;
            end else begin
                out_data.byte_value = buf_rd.byte_value;
                out_data.repeat_res = buf_rd.repeat_res;
            end
            out_data.last = drain_last;
        end else begin
            out_load = !r_flush && out_free &&
                       ((r_state == S_EMIT_C) || (r_state == S_EMIT_P));
            out_data.byte_value = emit_run.byte_value;
            out_data.repeat_res = emit_run.repeat_res;
            out_data.last       = 1'b0;
        end
    end

    // Sequence the coder
    always_comb begin
        n_state     = r_state;
        n_low       = r_low;
        n_range     = r_range;
        n_cache     = r_cache;
        n_pend      = r_pend;
        n_flush     = r_flush;
        n_nshift    = r_nshift;
        n_rd        = r_rd;
        n_carry     = r_carry;
        n_rel_cache = r_rel_cache;
        n_rel_pend  = r_rel_pend;
        ser_ctl.load    = 1'b0;
        ser_ctl.advance = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    if (i_req.operation == OP_FLUSH) begin
                        n_flush = 1'b1;
                        n_state = S_ROUND;
                    end else if (i_req.bit_count != '0) begin
                        ser_ctl.load = 1'b1;
                        n_state      = S_BIT;
                    end
                end
            end
            S_BIT: begin
                ser_ctl.advance = 1'b1;
                if (ser_stat.bit_now) begin
                    n_low = r_low + C_LOW_W'(bound);
                end
                if (need_shift) begin
                    n_range = range_c << C_BYTE_W;
                    n_state = S_SHIFT;
                end else begin
                    n_range = range_c;
                    n_state = ser_stat.last ? S_IDLE : S_BIT;
                end
            end
            S_SHIFT: begin
                if (r_flush) begin
                    n_nshift = shifts_done;
                end
                if (release_run) begin
                    n_carry     = r_low[C_LOW_W-1];
                    n_rel_cache = r_cache;
                    n_rel_pend  = r_pend;
                    n_cache     = r_low[C_RANGE_W-1 -: C_BYTE_W];
                    n_pend      = PENDING_COUNT_BITS'(1);
                    n_state     = S_EMIT_C;
                end else begin
                    if (r_pend != '1) begin
                        n_pend = r_pend + 1'b1;
                    end
                    n_state = cont_state;
                end
                n_low = C_LOW_W'({r_low[C_RANGE_W-C_BYTE_W-1:0], {C_BYTE_W{1'b0}}});
            end
            S_EMIT_C: begin
                if (emit_go) begin
                    n_state = (r_rel_pend > PENDING_COUNT_BITS'(1)) ? S_EMIT_P : cont_state;
                end
            end
            S_EMIT_P: begin
                if (emit_go) begin
                    n_state = cont_state;
                end
            end
            S_ROUND: begin
                if ((r_low & round_mask) != '0) begin
                    n_low = (r_low + round_unit) & ~round_mask;
                end
                n_nshift = '0;
                n_rd     = '0;
                n_state  = S_SHIFT;
            end
            S_DRAIN: begin
                if (out_free) begin
                    if (drain_last) begin
                        n_low   = '0;
                        n_range = '1;
                        n_cache = '0;
                        n_pend  = PENDING_COUNT_BITS'(1);
                        n_flush = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_rd = r_rd + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold coder state; reset returns it to the start of a stream
    always_ff @(posedge i_clk) begin
        r_carry     <= n_carry;
        r_rel_cache <= n_rel_cache;
        r_rel_pend  <= n_rel_pend;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_low    <= '0;
            r_range  <= '1;
            r_cache  <= '0;
            r_pend   <= PENDING_COUNT_BITS'(1);
            r_flush  <= 1'b0;
            r_nshift <= '0;
            r_rd     <= '0;
        end else begin
            r_state  <= n_state;
            r_low    <= n_low;
            r_range  <= n_range;
            r_cache  <= n_cache;
            r_pend   <= n_pend;
            r_flush  <= n_flush;
            r_nshift <= n_nshift;
            r_rd     <= n_rd;
        end
    end

    `RCBB_ASSERT_HOLDS(a_range_norm, r_state == S_IDLE, r_range[C_RANGE_W-1:C_TOP_BITS] != '0, "range not normalized between requests")
    `RCBB_ASSERT_NEXT(a_flush_resets, drain_fin, (r_low == '0) && (r_cache == '0) && (r_pend == PENDING_COUNT_BITS'(1)) && !r_flush, "coder not back at stream start after flush")
    `RCBB_ASSERT_HOLDS(a_shift_count, r_flush, r_nshift <= C_SHIFT_CNT_W'(C_FLUSH_SHIFTS), "flush shift count overrun")
    `RCBB_ASSERT_HOLDS(a_pend_run, r_state == S_EMIT_P, r_rel_pend > PENDING_COUNT_BITS'(1), "empty pending run released")

endmodule
